FILE: hdl/cpu_ready_queue_scheduler_unit_macros.svh
// Assertion macros shared by the checker.
`ifndef CPU_READY_QUEUE_SCHEDULER_UNIT_MACROS_SVH
`define CPU_READY_QUEUE_SCHEDULER_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CRQS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CRQS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: hdl/crqs_pkg.sv
`timescale 1ns / 1ps
package crqs_pkg;
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_PICK   = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;
    localparam logic [1:0] ST_IDLE = 2'd3;

    localparam logic [2:0] POL_FCFS   = 3'd0;
    localparam logic [2:0] POL_PSJF   = 3'd1;
    localparam logic [2:0] POL_NSJF   = 3'd2;
    localparam logic [2:0] POL_PPRIO  = 3'd3;
    localparam logic [2:0] POL_NPRIO  = 3'd4;
    localparam logic [2:0] POL_RR     = 3'd5;

    localparam logic CFG_POLICY  = 1'b0;
    localparam logic CFG_QUANTUM = 1'b1;

    localparam logic [7:0] QUANTUM_RESET = 8'd3;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] left;
        logic [15:0] arr;
        logic [7:0]  prio;
    } entry_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic scan_clear;   // start a scan at position zero
        logic scan_step;    // compare the entry at the scan position
        logic exec;         // apply the command using the scan results
        logic shift_step;   // move the entry one place toward the head
        logic compact_end;  // shrink the queue or requeue the displaced task
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_done;   // every stored entry has been visited
        logic shift_done;  // compaction reached the tail
        logic need_shift;  // exec removed an entry from the queue
    } dp_sts_t;
endpackage

FILE: hdl/crqs_ctrl.sv
`timescale 1ns / 1ps
module crqs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output crqs_pkg::dp_cmd_t cmd,
    input  crqs_pkg::dp_sts_t sts
);
    import crqs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.scan_clear = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.scan_done) begin
                    state_next = S_EXEC;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                state_next = sts.need_shift ? S_SHIFT : S_OUT;
            end
            S_SHIFT: begin
                if (sts.shift_done) begin
                    cmd.compact_end = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

FILE: hdl/crqs_datapath.sv
`timescale 1ns / 1ps
module crqs_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [1:0]        s_func,
    input  logic [7:0]        s_task_id,
    input  logic [15:0]       s_burst_left,
    input  logic [15:0]       s_arrival_time,
    input  logic [7:0]        s_prio_level,
    input  logic              cfg_valid,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    input  crqs_pkg::dp_cmd_t cmd,
    output crqs_pkg::dp_sts_t sts,
    output logic [1:0]        m_status,
    output logic              m_run_valid,
    output logic [7:0]        m_run_id,
    output logic [15:0]       m_run_left,
    output logic              m_preempted,
    output logic              m_finished,
    output logic [7:0]        m_finished_id
);
    import crqs_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    entry_t            q_reg [QUEUE_DEPTH];
    logic [CW-1:0]     count_reg;
    entry_t            run_reg;
    logic              present_reg;
    logic [7:0]        slice_reg;
    logic [2:0]        policy_reg;
    logic [7:0]        quantum_reg;

    logic [1:0]        func_reg;
    entry_t            in_reg;
    logic [CW-1:0]     pos_reg;     // scan and shift position
    logic [IW-1:0]     best_reg;
    logic              dup_reg;
    entry_t            tail_reg;    // entry appended after compaction
    logic              tail_en_reg;

    logic [1:0]        status_reg;
    logic              preempt_reg, fin_reg;
    logic [7:0]        fin_id_reg;

    logic              by_prio;
    logic              preemptive;
    entry_t            cur, bst;
    logic              cur_beats;
    logic              retire;

    function automatic logic beats(entry_t a, entry_t b, logic bp);
        logic [15:0] ka, kb;
        ka = bp ? {8'd0, a.prio} : a.left;
        kb = bp ? {8'd0, b.prio} : b.left;
        return (ka < kb) || ((ka == kb) && (a.arr < b.arr));
    endfunction

    assign by_prio    = (policy_reg == POL_PPRIO) || (policy_reg == POL_NPRIO);
    assign preemptive = (policy_reg == POL_PSJF) || (policy_reg == POL_PPRIO);
    assign cur        = q_reg[pos_reg[IW-1:0]];
    assign bst        = q_reg[best_reg];
    assign cur_beats  = beats(cur, bst, by_prio);
    assign retire     = (func_reg == FUNC_TICK) && present_reg && (run_reg.left <= 16'd1);

    // Decision logic evaluated during exec.
    logic          take;
    logic          rotate;
    logic [IW-1:0] take_pos;

    always_comb begin
        take = 1'b0;
        rotate = 1'b0;
        take_pos = '0;
        if (func_reg == FUNC_PICK && count_reg != '0 && policy_reg <= POL_RR) begin
            if (policy_reg == POL_FCFS || policy_reg == POL_RR) begin
                take_pos = '0;
                if (!present_reg) begin
                    take = 1'b1;
                end else if (policy_reg == POL_RR && slice_reg >= quantum_reg) begin
                    take = 1'b1;
                    rotate = 1'b1;
                end
            end else begin
                take_pos = best_reg;
                if (!present_reg) begin
                    take = 1'b1;
                end else if (preemptive && beats(bst, run_reg, by_prio)) begin
                    take = 1'b1;
                    rotate = 1'b1;
                end
            end
        end
    end

    assign sts = '{scan_done:  (pos_reg == count_reg),
                   shift_done: (pos_reg + CW'(1) >= count_reg),
                   need_shift: take};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            run_reg     <= '0;
            present_reg <= 1'b0;
            slice_reg   <= '0;
            policy_reg  <= POL_FCFS;
            quantum_reg <= QUANTUM_RESET;
            tail_en_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_POLICY:  policy_reg  <= cfg_data[2:0];
                    CFG_QUANTUM: quantum_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                func_reg <= s_func;
                in_reg   <= '{s_task_id, s_burst_left, s_arrival_time, s_prio_level};
            end
            if (cmd.scan_clear) begin
                pos_reg  <= '0;
                best_reg <= '0;
                dup_reg  <= 1'b0;
            end
            if (cmd.scan_step) begin
                if (cur.id == in_reg.id) dup_reg <= 1'b1;
                if (pos_reg != '0 && cur_beats) best_reg <= pos_reg[IW-1:0];
                pos_reg <= pos_reg + CW'(1);
            end
            if (cmd.exec) begin
                preempt_reg <= rotate;
                fin_reg     <= retire;
                fin_id_reg  <= retire ? run_reg.id : 8'd0;
                pos_reg     <= CW'(take_pos);
                tail_en_reg <= rotate;
                tail_reg    <= run_reg;
                case (func_reg)
                    FUNC_INSERT: begin
                        if (count_reg >= CW'(QUEUE_DEPTH)) begin
                            status_reg <= ST_FULL;
                        end else if (dup_reg) begin
                            status_reg <= ST_DUP;
                        end else begin
                            status_reg <= ST_OK;
                            q_reg[count_reg[IW-1:0]] <= in_reg;
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                    FUNC_PICK: begin
                        if (take) begin
                            run_reg     <= q_reg[take_pos];
                            present_reg <= 1'b1;
                            slice_reg   <= '0;
                        end
                        status_reg <= (take || present_reg) ? ST_OK : ST_IDLE;
                    end
                    FUNC_TICK: begin
                        if (!present_reg) begin
                            status_reg <= ST_IDLE;
                        end else if (retire) begin
                            status_reg   <= ST_OK;
                            run_reg.left <= '0;
                            present_reg  <= 1'b0;
                            slice_reg    <= '0;
                        end else begin
                            status_reg   <= ST_OK;
                            run_reg.left <= run_reg.left - 16'd1;
                            if (slice_reg != 8'hFF) slice_reg <= slice_reg + 8'd1;
                        end
                    end
                    default: status_reg <= ST_OK;
                endcase
            end
            if (cmd.shift_step) begin
                q_reg[pos_reg[IW-1:0]] <= q_reg[IW'(pos_reg + CW'(1))];
                pos_reg <= pos_reg + CW'(1);
            end
            // Compaction finished: the tail slot takes the displaced task, or the
            // queue shrinks by the entry that was taken.
            if (cmd.compact_end) begin
                if (tail_en_reg) begin
                    q_reg[IW'(count_reg - CW'(1))] <= tail_reg;
                end else begin
                    count_reg <= count_reg - CW'(1);
                end
            end
        end
    end

    assign m_status      = status_reg;
    assign m_run_valid   = present_reg;
    assign m_run_id      = present_reg ? run_reg.id : 8'd0;
    assign m_run_left    = present_reg ? run_reg.left : 16'd0;
    assign m_preempted   = preempt_reg;
    assign m_finished    = fin_reg;
    assign m_finished_id = fin_id_reg;
endmodule

FILE: hdl/cpu_ready_queue_scheduler_unit.sv
`timescale 1ns / 1ps
// Ready-queue scheduler: every request (insert, pick, tick, unused code) is
// taken when s_ready is high and yields one result on the m_ channel. Each
// request runs the compare scan over the ready queue (duplicate search and
// best-candidate search) and an execute step; when pick removes an entry, a
// compaction moves every entry behind it one place toward the head, closes the
// gap and, on a preemption, requeues the displaced task, all over the single
// queue register file. The result is then presented until it is taken. A new
// request waits until the result has been taken and is accepted in the cycle
// after at the earliest. Configuration writes (index 0 policy, 1 quantum) are
// always accepted and must only be issued while the block is idle.
module cpu_ready_queue_scheduler_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_task_id,
    input  logic [15:0] s_burst_left,
    input  logic [15:0] s_arrival_time,
    input  logic [7:0]  s_prio_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_run_valid,
    output logic [7:0]  m_run_id,
    output logic [15:0] m_run_left,
    output logic        m_preempted,
    output logic        m_finished,
    output logic [7:0]  m_finished_id,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import crqs_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Configuration registers are written directly; the port never stalls.
    assign cfg_ready = 1'b1;

    crqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    crqs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_task_id      (s_task_id),
        .s_burst_left   (s_burst_left),
        .s_arrival_time (s_arrival_time),
        .s_prio_level   (s_prio_level),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .sts            (sts),
        .m_status       (m_status),
        .m_run_valid    (m_run_valid),
        .m_run_id       (m_run_id),
        .m_run_left     (m_run_left),
        .m_preempted    (m_preempted),
        .m_finished     (m_finished),
        .m_finished_id  (m_finished_id)
    );
endmodule

FILE: hdl/crqs_checker.sv
`timescale 1ns / 1ps
`include "cpu_ready_queue_scheduler_unit_macros.svh"
module crqs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic        m_run_valid,
    input logic [7:0]  m_run_id,
    input logic        m_preempted,
    input logic        m_finished
);
    import crqs_pkg::*;

    `CRQS_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_valid, !s_ready, "request taken during result")
    `CRQS_ASSERT_IMP(a_idle_status, aclk, aresetn, m_valid && m_run_valid, m_status != ST_IDLE, "idle status with running task")
    `CRQS_ASSERT_IMP(a_fin_clears, aclk, aresetn, m_valid && m_finished, !m_run_valid && !m_preempted, "retire left a running task")
    `CRQS_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, !m_valid, "result in cycle after accept")
    `CRQS_ASSERT_IMP(a_no_id_idle, aclk, aresetn, m_valid && !m_run_valid, m_run_id == 8'd0, "id shown without task")
endmodule

bind cpu_ready_queue_scheduler_unit crqs_checker u_crqs_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_run_valid (m_run_valid),
    .m_run_id    (m_run_id),
    .m_preempted (m_preempted),
    .m_finished  (m_finished)
);

FILE: tb/tb_cpu_ready_queue_scheduler_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for the ready-queue scheduler. A directed table opens the run.
// Random insert, pick and tick requests follow under every policy and several quanta.
// Each request is fed to a behavioral scheduler kept in the bench. The result it
// predicts is queued and compared field by field with the block's result.
module tb_cpu_ready_queue_scheduler_unit;
    import crqs_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [1:0]  status;
        logic        run_valid;
        logic [7:0]  run_id;
        logic [15:0] run_left;
        logic        preempted;
        logic        finished;
        logic [7:0]  finished_id;
    } sched_result_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  id;
        logic [15:0] left;
        logic [15:0] arr;
        logic [7:0]  prio;
    } sched_request_t;

    // A directed row: the request, and, where it is obvious, the exact result.
    typedef struct packed {
        sched_request_t req;
        logic           has_fixed;
        sched_result_t  fixed;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = FUNC_INSERT;
    logic [7:0]  s_task_id = '0;
    logic [15:0] s_burst_left = '0;
    logic [15:0] s_arrival_time = '0;
    logic [7:0]  s_prio_level = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_run_valid;
    logic [7:0]  m_run_id;
    logic [15:0] m_run_left;
    logic        m_preempted;
    logic        m_finished;
    logic [7:0]  m_finished_id;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_POLICY;
    logic [7:0]  cfg_data = '0;

    cpu_ready_queue_scheduler_unit #(.QUEUE_DEPTH(DEPTH)) u_top (.*);

    always #4 aclk = ~aclk;

    // Shadow copy of the scheduler state.
    entry_t         sh_queue[$];
    entry_t         sh_run;
    logic           sh_run_present;
    logic [7:0]     sh_slice;
    logic [2:0]     sh_policy;
    logic [7:0]     sh_quantum;

    sched_result_t  expected_results[$];
    logic           fixed_flags[$];
    sched_result_t  fixed_results[$];
    bit             any_error = 1'b0;
    bit             calm_phase = 1'b0;
    int             cycle_count = 0;

    function automatic bit outranks(entry_t a, entry_t b, bit by_prio);
        logic [15:0] ka;
        logic [15:0] kb;
        ka = by_prio ? {8'd0, a.prio} : a.left;
        kb = by_prio ? {8'd0, b.prio} : b.left;
        return (ka < kb) || (ka == kb && a.arr < b.arr);
    endfunction

    // Executes one pick on the shadow state and reports a preemption.
    function automatic bit shadow_pick();
        int best;
        bit by_prio;
        bit preemptive;
        entry_t old;
        if (sh_queue.size() == 0 || sh_policy > POL_RR) return 1'b0;
        if (sh_policy == POL_FCFS || sh_policy == POL_RR) begin
            if (!sh_run_present) begin
                sh_run = sh_queue.pop_front();
                sh_run_present = 1'b1;
                sh_slice = '0;
                return 1'b0;
            end
            if (sh_policy == POL_RR && sh_slice >= sh_quantum) begin
                old = sh_run;
                sh_run = sh_queue.pop_front();
                sh_queue.push_back(old);
                sh_slice = '0;
                return 1'b1;
            end
            return 1'b0;
        end
        by_prio = (sh_policy == POL_PPRIO || sh_policy == POL_NPRIO);
        preemptive = (sh_policy == POL_PSJF || sh_policy == POL_PPRIO);
        best = 0;
        for (int i = 1; i < sh_queue.size(); i++)
            if (outranks(sh_queue[i], sh_queue[best], by_prio)) best = i;
        if (!sh_run_present) begin
            sh_run = sh_queue[best];
            sh_queue.delete(best);
            sh_run_present = 1'b1;
            sh_slice = '0;
            return 1'b0;
        end
        if (preemptive && outranks(sh_queue[best], sh_run, by_prio)) begin
            old = sh_run;
            sh_run = sh_queue[best];
            sh_queue.delete(best);
            sh_queue.push_back(old);
            sh_slice = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic sched_result_t predict_schedule(sched_request_t req);
        sched_result_t r;
        entry_t e;
        bit dup;
        r = '0;
        case (req.func)
            FUNC_INSERT: begin
                e = '{id: req.id, left: req.left, arr: req.arr, prio: req.prio};
                dup = 1'b0;
                foreach (sh_queue[i]) if (sh_queue[i].id == req.id) dup = 1'b1;
                if (sh_queue.size() >= DEPTH) r.status = ST_FULL;
                else if (dup) r.status = ST_DUP;
                else sh_queue.push_back(e);
            end
            FUNC_PICK: begin
                r.preempted = shadow_pick();
                r.status = sh_run_present ? ST_OK : ST_IDLE;
            end
            FUNC_TICK: begin
                if (!sh_run_present) begin
                    r.status = ST_IDLE;
                end else if (sh_run.left <= 16'd1) begin
                    r.finished = 1'b1;
                    r.finished_id = sh_run.id;
                    sh_run.left = '0;
                    sh_run_present = 1'b0;
                    sh_slice = '0;
                end else begin
                    sh_run.left = sh_run.left - 16'd1;
                    if (sh_slice != 8'hFF) sh_slice = sh_slice + 8'd1;
                end
            end
            default: ;
        endcase
        r.run_valid = sh_run_present;
        r.run_id = sh_run_present ? sh_run.id : 8'd0;
        r.run_left = sh_run_present ? sh_run.left : 16'd0;
        return r;
    endfunction

    // Random stall on the result side; none in the final calm phase.
    int stall_left = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (!aresetn || calm_phase) begin
            m_ready <= aresetn;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 15) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result checker: every accepted result is compared with the oldest prediction.
    always @(posedge aclk) begin
        sched_result_t got;
        sched_result_t want;
        logic fixed_flag;
        sched_result_t fixed_want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_status, m_run_valid, m_run_id, m_run_left, m_preempted,
                    m_finished, m_finished_id};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                any_error = 1'b1;
            end else begin
                want = expected_results.pop_front();
                fixed_flag = fixed_flags.pop_front();
                fixed_want = fixed_results.pop_front();
                if (got.status != want.status || got.run_valid != want.run_valid ||
                    got.run_id != want.run_id || got.run_left != want.run_left ||
                    got.preempted != want.preempted || got.finished != want.finished ||
                    got.finished_id != want.finished_id) begin
                    $display("%0t: result mismatch, expected %h actual %h",
                             $time, want, got);
                    any_error = 1'b1;
                end
                // Hand-typed rows must also agree with the block's result.
                if (fixed_flag && fixed_want != got) begin
                    $display("%0t: directed row mismatch, expected %h actual %h",
                             $time, fixed_want, got);
                    any_error = 1'b1;
                end
            end
        end
    end

    // Sends one request, holding valid until the block takes it. The block is busy
    // after an accept, so valid is dropped before the next request.
    task automatic send_request(sched_request_t req, logic has_fixed,
                                sched_result_t fixed);
        int gap;
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= req.func;
        s_task_id <= req.id;
        s_burst_left <= req.left;
        s_arrival_time <= req.arr;
        s_prio_level <= req.prio;
        expected_results.push_back(predict_schedule(req));
        fixed_flags.push_back(has_fixed);
        fixed_results.push_back(fixed);
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_register(logic idx, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_POLICY) sh_policy = value[2:0];
        else sh_quantum = value;
        @(posedge aclk);
    endtask

    // Waits for all outstanding results; every request yields one, so no extra drain.
    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Random request mix, with ids drawn from 0 to id_span so small spans give duplicates.
    function automatic sched_request_t random_request(int id_span);
        sched_request_t q;
        int k;
        k = $urandom_range(0, 9);
        q.func = (k < 4) ? FUNC_INSERT : (k < 6) ? FUNC_PICK : FUNC_TICK;
        if ($urandom_range(0, 99) == 0) q.func = 2'd3;
        q.id = (id_span >= 255) ? 8'($urandom) : 8'($urandom_range(0, id_span));
        q.left = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
        q.arr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
        q.prio = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        return q;
    endfunction

    directed_row_t directed_table[$];

    function automatic directed_row_t row(logic [1:0] f, logic [7:0] id, logic [15:0] l,
                                          logic [15:0] a, logic [7:0] p, logic hf,
                                          sched_result_t fx);
        directed_row_t d;
        d.req = '{f, id, l, a, p};
        d.has_fixed = hf;
        d.fixed = fx;
        return d;
    endfunction

    initial begin
        sched_result_t none;
        int policies[8];
        int quanta[8];
        none = '0;
        sh_queue = {};
        sh_run = '0;
        sh_run_present = 1'b0;
        sh_slice = '0;
        sh_policy = POL_FCFS;
        sh_quantum = QUANTUM_RESET;

        // Right after reset: idle pick and tick, extreme fields, a duplicate id.
        directed_table.push_back(row(FUNC_PICK, 8'd0, 16'd0, 16'd0, 8'd0, 1'b1,
            '{ST_IDLE, 1'b0, 8'd0, 16'd0, 1'b0, 1'b0, 8'd0}));
        directed_table.push_back(row(FUNC_TICK, 8'd0, 16'd0, 16'd0, 8'd0, 1'b1,
            '{ST_IDLE, 1'b0, 8'd0, 16'd0, 1'b0, 1'b0, 8'd0}));
        directed_table.push_back(row(2'd3, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, none));
        directed_table.push_back(row(FUNC_INSERT, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
                                     none));
        directed_table.push_back(row(FUNC_INSERT, 8'hFF, 16'd1, 16'd0, 8'd0, 1'b1,
            '{ST_DUP, 1'b0, 8'd0, 16'd0, 1'b0, 1'b0, 8'd0}));
        directed_table.push_back(row(FUNC_INSERT, 8'h00, 16'd0, 16'd0, 8'd0, 1'b1, none));
        directed_table.push_back(row(FUNC_PICK, 8'd0, 16'd0, 16'd0, 8'd0, 1'b1,
            '{ST_OK, 1'b1, 8'hFF, 16'hFFFF, 1'b0, 1'b0, 8'd0}));
        directed_table.push_back(row(FUNC_TICK, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0, none));
        directed_table.push_back(row(FUNC_PICK, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0, none));
        // Under FCFS a pick with a task already running changes nothing.
        directed_table.push_back(row(FUNC_PICK, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0, none));
        directed_table.push_back(row(FUNC_TICK, 8'd0, 16'd0, 16'd0, 8'd0, 1'b0, none));
        // Fill to capacity; the last loop insert and one more insert must report a full queue.
        for (int i = 1; i <= DEPTH; i++)
            directed_table.push_back(row(FUNC_INSERT, 8'(i), 16'(i), 16'(DEPTH - i),
                                         8'(i % 3), 1'b0, none));
        directed_table.push_back(row(FUNC_INSERT, 8'hAA, 16'd5, 16'd5, 8'd5, 1'b1,
            '{ST_FULL, 1'b1, 8'hFF, 16'hFFFD, 1'b0, 1'b0, 8'd0}));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_table[i])
            send_request(directed_table[i].req, directed_table[i].has_fixed,
                         directed_table[i].fixed);
        wait_drained();

        // Random phases over every policy, an unused code and quantum extremes.
        policies = '{POL_FCFS, POL_PSJF, POL_NSJF, POL_PPRIO, POL_NPRIO, POL_RR,
                     POL_RR, 3'd7};
        quanta = '{1, 255, 0, 2, 3, 1, 0, 6};
        for (int ph = 0; ph < 8; ph++) begin
            write_register(CFG_POLICY, 8'(policies[ph]));
            write_register(CFG_QUANTUM, 8'(quanta[ph]));
            if (ph == 7) calm_phase = 1'b1;
            for (int n = 0; n < 60; n++)
                send_request(random_request(ph == 2 ? 255 : 20), 1'b0, none);
            wait_drained();
            // Switch back to a working policy after every phase and flush the queue.
            write_register(CFG_POLICY, 8'(POL_FCFS));
            for (int n = 0; n < 12 && (sh_queue.size() != 0 || sh_run_present); n++) begin
                send_request('{FUNC_PICK, 8'd0, 16'd0, 16'd0, 8'd0}, 1'b0, none);
                send_request('{FUNC_TICK, 8'd0, 16'd0, 16'd0, 8'd0}, 1'b0, none);
            end
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (expected_results.size() != 0) any_error = 1'b1;
        if (!any_error) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end
endmodule

FILE: files.f
+incdir+hdl
hdl/crqs_pkg.sv
hdl/crqs_ctrl.sv
hdl/crqs_datapath.sv
hdl/cpu_ready_queue_scheduler_unit.sv
hdl/crqs_checker.sv
tb/tb_cpu_ready_queue_scheduler_unit.sv
